// ===== rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int unsigned CLOCK_HZ  = 24000000;
  localparam int unsigned FREQ_W    = 24;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned PER_W     = 16;
  localparam int unsigned NUM_DIV   = 8;
  localparam int unsigned FULL_DUTY = 100;
  localparam int unsigned MAX_COUNT = 65536;
  localparam logic [SEL_W-1:0] SEL_SLOW = 3'd7;

  // product of period and saturated duty
  localparam int unsigned PROD_W = PER_W + PCT_W;
  localparam int unsigned CLK_W  = $clog2(CLOCK_HZ + 1);
  // dividend width of the divider, clock over frequency
  localparam int unsigned DIV_W  = CLK_W;
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);

  // x / 100 as (x * ceil(2^30 / 100)) >> 30, exact for every x below 2^23
  localparam int unsigned RECIP_W     = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RECIP_W-1:0] RECIP_DUTY = 24'd10737419;
  localparam int unsigned SCALE_W     = PROD_W + RECIP_W;

  // prescaler dividers are powers of two: 1,2,4,8,16,64,256,1024
  localparam int unsigned SHIFT_W = 4;
  localparam logic [SHIFT_W-1:0] DIV_SHIFT [NUM_DIV] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10
  };

  typedef struct packed {
    logic [FREQ_W-1:0] freq_hz;
    logic [DUTY_W-1:0] duty_pct;
  } in_item_t;

  typedef struct packed {
    logic [SEL_W-1:0] prescale_sel;
    logic [PER_W-1:0] period_reg;
    logic [PER_W-1:0] compare_value;
    logic             out_of_range;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [PER_W-1:0] period;
    logic             flag;
  } pick_t;

endpackage

// ===== rtl/pwm_prescaler_period_calculator.sv =====
`timescale 1ns / 1ps
// one restoring divider gives floor(clock/freq), one quotient bit per cycle;
// the duty scaling divides by 100 through a reciprocal multiply (S_MUL, S_SCALE)
// one item in flight: the next item is taken the cycle after the result loads,
// and the block stays busy while a finished result waits on out_stall_i
// reset (asynchronous, active low) returns the sequencer to idle and drops out_valid_o
module pwm_prescaler_period_calculator
  import ppc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_MUL,
    S_SCALE,
    S_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [PCT_W-1:0]  duty_q, duty_d;
  pick_t             pick_q, pick_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [PER_W-1:0]  comp_q, comp_d;
  div_req_t          req_q, req_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  pick_t             pick_w;
  logic [SCALE_W-1:0] scaled;
  logic              accept;

  ppc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  ppc_pick u_pick (
    .count_i (div_quo),
    .pick_o  (pick_w)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // compare value is the top bits of product times reciprocal of 100
  assign scaled = SCALE_W'(prod_q) * SCALE_W'(RECIP_DUTY);

  always_comb begin
    state_d     = state_q;
    duty_d      = duty_q;
    pick_d      = pick_q;
    prod_d      = prod_q;
    comp_d      = comp_q;
    req_d       = req_q;
    req_d.start = 1'b0;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          duty_d = (in_item_i.duty_pct > DUTY_W'(FULL_DUTY)) ? PCT_W'(FULL_DUTY)
                                                              : in_item_i.duty_pct[PCT_W-1:0];
          req_d.start    = 1'b1;
          req_d.dividend = DIV_W'(CLOCK_HZ);
          // zero frequency counts as 1 Hz
          req_d.divisor  = (in_item_i.freq_hz == '0) ? FREQ_W'(1) : in_item_i.freq_hz;
          state_d        = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          pick_d  = pick_w;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(pick_q.period) * PROD_W'(duty_q);
        state_d = S_SCALE;
      end
      S_SCALE: begin
        comp_d  = scaled[RECIP_SHIFT +: PER_W];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // output register free or being emptied this cycle
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                = 1'b1;
          out_item_d.prescale_sel    = pick_q.sel;
          out_item_d.period_reg      = pick_q.period;
          out_item_d.compare_value   = comp_q;
          out_item_d.out_of_range    = pick_q.flag;
          state_d                    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      duty_q      <= '0;
      pick_q      <= '0;
      prod_q      <= '0;
      comp_q      <= '0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      duty_q      <= duty_d;
      pick_q      <= pick_d;
      prod_q      <= prod_d;
      comp_q      <= comp_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("block took an item but did not go busy");

  a_clamp_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_of_range) |->
      (out_item_o.prescale_sel == SEL_SLOW && out_item_o.period_reg == '1))
    else $error("out of range result is not the slowest clamped setting");

  a_compare_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.compare_value <= out_item_o.period_reg))
    else $error("compare value above period");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV1))
    else $error("divider finished outside the divide step");

endmodule

// ===== rtl/ppc_div.sv =====
`timescale 1ns / 1ps
module ppc_div
  import ppc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FREQ_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [FREQ_W-1:0] dvs_q, dvs_d;
  logic              done_q, done_d;
  logic [FREQ_W:0]   rem_sh;
  logic [FREQ_W:0]   rem_sub;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = CNT_W'(DIV_W);
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      rem_d  = ge ? rem_sub[FREQ_W-1:0] : rem_sh[FREQ_W-1:0];
      quo_d  = {quo_q[DIV_W-2:0], ge};
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      done_q <= done_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/ppc_pick.sv =====
`timescale 1ns / 1ps
module ppc_pick
  import ppc_pkg::*;
(
  input  logic [DIV_W-1:0] count_i,
  output pick_t            pick_o
);

  logic [DIV_W-1:0]   cnt_s [NUM_DIV];
  logic [NUM_DIV-1:0] fit;

  // count for divider i is the base count shifted down, floors nest exactly
  always_comb begin
    for (int i = 0; i < NUM_DIV; i++) begin
      cnt_s[i] = count_i >> DIV_SHIFT[i];
      fit[i]   = (cnt_s[i] != '0) && (cnt_s[i] <= DIV_W'(MAX_COUNT));
    end
  end

  always_comb begin
    pick_o.sel    = SEL_SLOW;
    pick_o.period = '1;
    pick_o.flag   = 1'b1;
    for (int i = NUM_DIV - 1; i >= 0; i--) begin
      if (fit[i]) begin
        pick_o.sel    = SEL_W'(i);
        pick_o.period = PER_W'(cnt_s[i] - 1'b1);
        pick_o.flag   = 1'b0;
      end
    end
  end

endmodule
